// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned PrioWidth    = 16;
  localparam int unsigned OccWidth     = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // per-cell control for the current cycle
  typedef struct packed {
    logic enq;  // accepted enqueue into a non-full queue
    logic deq;  // accepted dequeue from a non-empty queue
    logic occ;  // cell holds a live entry
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted shift chain: holds, inserts, or takes a neighbor entry.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                        clk_i,
  input  cell_ctrl_t                  ctrl_i,
  input  logic [DATA_WIDTH-1:0]       new_data_i,
  input  logic signed [PrioWidth-1:0] new_prio_i,
  input  logic                        left_stays_i,
  input  logic [DATA_WIDTH-1:0]       left_data_i,
  input  logic signed [PrioWidth-1:0] left_prio_i,
  input  logic [DATA_WIDTH-1:0]       right_data_i,
  input  logic signed [PrioWidth-1:0] right_prio_i,
  output logic                        stays_o,
  output logic [DATA_WIDTH-1:0]       data_o,
  output logic signed [PrioWidth-1:0] prio_o
);

  logic [DATA_WIDTH-1:0]       data_q, data_d;
  logic signed [PrioWidth-1:0] prio_q, prio_d;

  // entry ahead of the new word: equal priorities keep arrival order
  assign stays_o = ctrl_i.occ && (new_prio_i <= prio_q);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.enq && !stays_o) begin
      if (left_stays_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.deq) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue built as a shift chain of cells, front entry in cell 0.
// The result word is registered when the command is accepted and is valid in the following cycle.
// Throughput: one command per cycle unless the input is stalled; every cell compares and shifts in parallel.
// A result word held by a stalled receiver stalls the input until it is taken.
// Reset clears the internal entry count and the output valid flag; slot contents are
// left undefined and are never read before being written.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [DATA_WIDTH-1:0]       item_data_i,
  input  logic signed [PrioWidth-1:0] item_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [DATA_WIDTH-1:0]       out_data_o,
  output logic signed [PrioWidth-1:0] out_priority_o,
  output logic                        was_empty_o,
  output logic                        was_full_o,
  output logic [OccWidth-1:0]         occupancy_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic [CntWidth-1:0] count_q, count_d;
  logic                fire, full, empty, enq_ok, deq_ok;

  logic                        out_valid_q;
  logic [DATA_WIDTH-1:0]       out_data_q;
  logic signed [PrioWidth-1:0] out_prio_q;
  logic                        out_empty_q, out_full_q;
  logic [OccWidth-1:0]         occ_q;

  logic                        stays    [DEPTH];
  logic [DATA_WIDTH-1:0]       cell_data[DEPTH];
  logic signed [PrioWidth-1:0] cell_prio[DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntWidth'(DEPTH));
  assign empty      = (count_q == '0);
  assign enq_ok     = fire && (cmd_e'(command_i) == CMD_ENQ) && !full;
  assign deq_ok     = fire && (cmd_e'(command_i) == CMD_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t                  ctrl;
    logic                        left_stays;
    logic [DATA_WIDTH-1:0]       left_data, right_data;
    logic signed [PrioWidth-1:0] left_prio, right_prio;

    assign ctrl.enq = enq_ok;
    assign ctrl.deq = deq_ok;
    assign ctrl.occ = (CntWidth'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_stays = 1'b1;
      assign left_data  = item_data_i;
      assign left_prio  = item_priority_i;
    end else begin : g_body
      assign left_stays = stays[i-1];
      assign left_data  = cell_data[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = '0;
      assign right_prio = '0;
    end else begin : g_next
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i,
      .ctrl_i      (ctrl),
      .new_data_i  (item_data_i),
      .new_prio_i  (item_priority_i),
      .left_stays_i(left_stays),
      .left_data_i (left_data),
      .left_prio_i (left_prio),
      .right_data_i(right_data),
      .right_prio_i(right_prio),
      .stays_o     (stays[i]),
      .data_o      (cell_data[i]),
      .prio_o      (cell_prio[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + 1'b1;
    end else if (deq_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q  <= deq_ok ? cell_data[0] : '0;
      out_prio_q  <= deq_ok ? cell_prio[0] : '0;
      out_empty_q <= (cmd_e'(command_i) == CMD_DEQ) && empty;
      out_full_q  <= (cmd_e'(command_i) == CMD_ENQ) && full;
    end
  end

  // occupancy reports the low bits of the count
  always_ff @(posedge clk_i) begin
    if (fire) begin
      occ_q <= OccWidth'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_priority_o = out_prio_q;
  assign was_empty_o    = out_empty_q;
  assign was_full_o     = out_full_q;
  assign occupancy_o    = occ_q;

endmodule
